// File: sv/sli_pkg.sv
// package for the sorted list insert/delete block
// shared types: operation and status codes, per-cycle cell command
// no dependencies
package sli_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } sli_op_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DELETED  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } sli_status_e;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic signed [VALUE_W-1:0] value;
  } sli_cmd_t;

endpackage

// File: sv/sorted_list_insert_delete.sv
// top level of the sorted list insert/delete block
// a row of sli_cell instances plus count, pending and output registers
// depends on sli_pkg and sli_cell
//
//  channel  valid        stall        word
//  in       in_valid_i   in_stall_o   operation_i, value_i
//  out      out_valid_o  out_stall_i  status_o, count_o, nonempty_o,
//                                     min_value_o, max_value_o
//
// one word per cycle unless the output stalls; each result passes the pending
// and output registers; the cell row updates in the accept cycle, and min and
// max are read from the cells as pending moves out, so they never stall input
// reset clears the count and the handshake state; cell contents are not reset
// a stalled output holds the result and stalls the input once the
// pending stage is also full
module sorted_list_insert_delete import sli_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [COUNT_W-1:0]        count_o,
  output logic                      nonempty_o,
  output logic signed [VALUE_W-1:0] min_value_o,
  output logic signed [VALUE_W-1:0] max_value_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]             count_q, count_d;
  logic                      pend_q, pend_d;
  sli_status_e               pend_status_q, pend_status_d;
  logic                      out_valid_q, out_valid_d;
  sli_status_e               out_status_q;
  logic [COUNT_W-1:0]        out_count_q;
  logic                      out_nonempty_q;
  logic signed [VALUE_W-1:0] out_min_q, out_max_q;

  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       cell_le, cell_eq, cell_occ, cell_last;

  logic                      accept, move, full, found;
  sli_cmd_t                  cmd;
  logic signed [VALUE_W-1:0] max_sel, min_sel;
  logic [CW+COUNT_W-1:0]     count_ext;

  assign move       = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_q && !move;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign found      = |cell_eq;

  assign cmd.ins   = accept && (operation_i == OP_INSERT) && !full;
  assign cmd.del   = accept && (operation_i == OP_DELETE) && found;
  assign cmd.value = value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      left_le;
    logic signed [VALUE_W-1:0] left_val, right_val;

    assign cell_occ[i]  = (CW'(i) < count_q);
    assign cell_last[i] = (count_q == CW'(i + 1));

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_val = value_i;
    end else begin : g_mid
      assign left_le  = cell_le[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    sli_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (cell_occ[i]),
      .left_le_i   (left_le),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .le_o        (cell_le[i]),
      .eq_o        (cell_eq[i])
    );
  end

  always_comb begin
    count_d       = count_q;
    pend_status_d = pend_status_q;
    if (accept) begin
      if (operation_i == OP_INSERT) begin
        pend_status_d = full ? ST_FULL : ST_INSERTED;
        if (!full) begin
          count_d = count_q + CW'(1);
        end
      end else begin
        pend_status_d = found ? ST_DELETED : ST_NOTFOUND;
        if (found) begin
          count_d = count_q - CW'(1);
        end
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (move) begin
      out_valid_d = 1'b1;
    end
  end

  // largest value sits in the last occupied cell
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      max_sel = max_sel | (cell_val[i] & {VALUE_W{cell_last[i]}});
    end
    min_sel = cell_occ[0] ? cell_val[0] : '0;
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    if (move) begin
      out_status_q   <= pend_status_q;
      out_count_q    <= count_ext[COUNT_W-1:0];
      out_nonempty_q <= cell_occ[0];
      out_min_q      <= min_sel;
      out_max_q      <= max_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;
  assign nonempty_o  = out_nonempty_q;
  assign min_value_o = out_min_q;
  assign max_value_o = out_max_q;

endmodule

// File: sv/sli_cell.sv
// one cell of the sorted row: holds one stored value
// compares against the broadcast word and shifts from a neighbor
// depends on sli_pkg
module sli_cell import sli_pkg::*; (
  input  logic                      clk_i,
  input  sli_cmd_t                  cmd_i,
  input  logic                      occ_i,
  input  logic                      left_le_i,
  input  logic signed [VALUE_W-1:0] left_val_i,
  input  logic signed [VALUE_W-1:0] right_val_i,
  output logic signed [VALUE_W-1:0] val_o,
  output logic                      le_o,
  output logic                      eq_o
);

  logic signed [VALUE_W-1:0] val_q, val_d;
  logic                      lt;

  assign le_o = occ_i && (val_q <= cmd_i.value);
  assign lt   = occ_i && (val_q <  cmd_i.value);
  assign eq_o = occ_i && (val_q == cmd_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins && !le_o) begin
      val_d = left_le_i ? cmd_i.value : left_val_i;
    end else if (cmd_i.del && !lt) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: tb/sorted_list_insert_delete_test.sv
// self-checking testbench for sorted_list_insert_delete: directed and random words
// shadow store predicts status, count, nonempty flag, min and max per word
// depends on sli_pkg and the sorted_list_insert_delete rtl
module sorted_list_insert_delete_test;
  import sli_pkg::*;

  localparam int unsigned CAPACITY = 16;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct {
    sli_status_e        status;
    logic [COUNT_W-1:0] count;
    logic               nonempty;
    value_t             min_value;
    value_t             max_value;
  } list_result_t;

  class sorted_list_shadow;
    value_t       held_values[$];
    list_result_t expected_words[$];
    int           mismatch_count = 0;

    function void take_word(sli_op_e op, value_t v);
      list_result_t r;
      int           pos;
      int           k;
      pos = 0;
      if (op == OP_INSERT) begin
        if (held_values.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          while (pos < held_values.size() && held_values[pos] <= v) pos++;
          held_values.push_back(v);
          for (k = held_values.size() - 1; k > pos; k--) held_values[k] = held_values[k-1];
          held_values[pos] = v;
          r.status = ST_INSERTED;
        end
      end else begin
        while (pos < held_values.size() && held_values[pos] != v) pos++;
        if (pos >= held_values.size()) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (k = pos; k + 1 < held_values.size(); k++) held_values[k] = held_values[k+1];
          void'(held_values.pop_back());
          r.status = ST_DELETED;
        end
      end
      r.count = COUNT_W'(held_values.size());
      r.nonempty = held_values.size() > 0;
      r.min_value = r.nonempty ? held_values[0] : '0;
      r.max_value = r.nonempty ? held_values[held_values.size()-1] : '0;
      expected_words.push_back(r);
    endfunction

    function void check_word(logic [1:0] status, logic [COUNT_W-1:0] count, logic nonempty,
                             value_t min_value, value_t max_value);
      list_result_t e;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
        return;
      end
      e = expected_words.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        mismatch_count++;
      end
      if (count !== e.count) begin
        $error("count: expected %0d, actual %0d", e.count, count);
        mismatch_count++;
      end
      if (nonempty !== e.nonempty) begin
        $error("nonempty: expected %0d, actual %0d", e.nonempty, nonempty);
        mismatch_count++;
      end
      if (min_value !== e.min_value) begin
        $error("min_value: expected %0d, actual %0d", e.min_value, min_value);
        mismatch_count++;
      end
      if (max_value !== e.max_value) begin
        $error("max_value: expected %0d, actual %0d", e.max_value, max_value);
        mismatch_count++;
      end
    endfunction

    function value_t pick_held();
      return held_values[$urandom_range(0, held_values.size() - 1)];
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               operation_i = 1'b0;
  value_t             value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [COUNT_W-1:0] count_o;
  logic               nonempty_o;
  value_t             min_value_o;
  value_t             max_value_o;

  sorted_list_shadow shadow = new();
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  sorted_list_insert_delete #(.CAPACITY(CAPACITY)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .count_o     (count_o),
    .nonempty_o  (nonempty_o),
    .min_value_o (min_value_o),
    .max_value_o (max_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("sorted_list_insert_delete regression: fail");
    $finish;
  end

  task automatic send_word(sli_op_e op, value_t v);
    int gap;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    value_i = v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shadow.take_word(op, v);
  endtask

  function automatic value_t draw_value(sli_op_e op);
    int pick;
    pick = $urandom_range(0, 99);
    if (op == OP_DELETE && shadow.held_values.size() > 0 && pick < 65) return shadow.pick_held();
    if (pick < 80) return value_t'($urandom_range(0, 8)) - 4;
    if (pick < 90) begin
      case ($urandom_range(0, 4))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'h7ffffffe;
        3: return 32'h80000001;
        default: return '0;
      endcase
    end
    return value_t'($urandom());
  endfunction

  // receiver: random stall before each word, in bursts with and without stalls
  initial begin
    int n;
    int words;
    words = 0;
    forever begin
      if (words % 64 == 0) recv_idle = $urandom_range(0, 3) != 0;
      n = recv_idle ? $urandom_range(0, 14) : 0;
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      shadow.check_word(status_o, count_o, nonempty_o, min_value_o, max_value_o);
      words++;
    end
  end

  initial begin
    int      ins_pct;
    sli_op_e op;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty store, single element, extremes, duplicates, full store
    send_word(OP_DELETE, '0);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_DELETE, 32'sd6);
    send_word(OP_DELETE, 32'sd5);
    send_word(OP_INSERT, 32'h7fffffff);
    send_word(OP_INSERT, 32'h80000000);
    send_word(OP_INSERT, 32'h80000000);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, '1);
    send_word(OP_DELETE, 32'h80000000);
    for (int i = 0; i < 12; i++) send_word(OP_INSERT, value_t'($urandom_range(0, 200)) - 100);
    send_word(OP_INSERT, 32'sd7);
    send_word(OP_DELETE, 32'h7fffffff);
    send_word(OP_DELETE, 32'sd12345);

    ins_pct = 50;
    for (int i = 0; i < 1700; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: ins_pct = 20;
          1: ins_pct = 50;
          2: ins_pct = 80;
          default: ins_pct = 95;
        endcase
        send_idle = $urandom_range(0, 3) != 0;
      end
      if (i == 850) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (shadow.expected_words.size() != 0) @(posedge clk_i);
      end
      op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
      send_word(op, draw_value(op));
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (shadow.expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (shadow.mismatch_count == 0) begin
      $display("sorted_list_insert_delete regression: pass");
    end else begin
      $display("sorted_list_insert_delete regression: fail");
    end
    $finish;
  end

endmodule
